// ===== rtl/lru_pkg.sv =====
package lru_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 20;
    localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int CFG_W     = 5;
    localparam int FAULT_W   = 32;

    localparam logic [CFG_W-1:0]   ACTIVE_RESET = CFG_W'(16);
    localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

    typedef logic [FRAMES-1:0]                 t_frame_mask;
    typedef logic [FRAMES-1:0][PAGE_BITS-1:0]  t_tag_arr;
    typedef logic [FRAMES-1:0][SLOT_W-1:0]     t_rank_arr;

    typedef struct packed {
        logic              hit;
        logic              fill;
        t_frame_mask       sel;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] old_rank;
    } t_lookup;

endpackage

// ===== rtl/lru_in_if.sv =====
interface lru_in_if import lru_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

// ===== rtl/lru_out_if.sv =====
interface lru_out_if import lru_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic [FAULT_W-1:0] fault_count;

    modport source (output valid, output hit, output frame_slot, output fault_count,
                    input ready);
    modport sink   (input valid, input hit, input frame_slot, input fault_count,
                    output ready);
endinterface

// ===== rtl/lru_lookup.sv =====
module lru_lookup import lru_pkg::*; (
    input  logic [PAGE_BITS-1:0] i_page,
    input  t_tag_arr             i_tags,
    input  t_frame_mask          i_valid,
    input  t_rank_arr            i_rank,
    input  logic [CNT_W-1:0]     i_active,
    input  logic [CNT_W-1:0]     i_filled,
    output t_lookup              o_lookup
);

    t_frame_mask       in_range;
    t_frame_mask       match;
    t_frame_mask       first;
    t_frame_mask       oldest;
    t_frame_mask       free_sel;
    t_frame_mask       sel;
    logic              hit;
    logic              fill;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] old_rank;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            in_range[i] = CNT_W'(i) < i_active;
            match[i]    = i_valid[i] && in_range[i] && (i_tags[i] == i_page);
            free_sel[i] = CNT_W'(i) == i_filled;
        end
    end

    // ranks of the valid frames are distinct, so exactly one in range dominates
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            oldest[i] = in_range[i];
            for (int j = 0; j < FRAMES; j++) begin
                if (j != i && in_range[j] && !(i_rank[j] < i_rank[i])) begin
                    oldest[i] = 1'b0;
                end
            end
        end
    end

    assign first = match & (~match + t_frame_mask'(1));
    assign hit   = |match;
    assign fill  = !hit && (i_filled < i_active);
    assign sel   = hit ? first : (fill ? free_sel : oldest);

    always_comb begin
        slot     = '0;
        old_rank = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (sel[i]) begin
                slot     = slot | SLOT_W'(i);
                old_rank = old_rank | i_rank[i];
            end
        end
    end

    assign o_lookup = '{hit: hit, fill: fill, sel: sel, slot: slot, old_rank: old_rank};

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// LRU page replacement unit: each page reference entering on i_req gives one result on
// o_rsp (hit flag, frame holding the page, saturating fault total). One reference is
// taken every cycle unless o_rsp stalls a waiting result; the reference is registered
// on acceptance and, once the result register is free, resolved by a single pass of
// 16-way tag compare, oldest-frame select and rank update into the result register.
// i_cfg_wdata sets the number of frames in use (0 acts as 1, above 16 as 16); write it
// only while no reference is in flight.
module lru_page_replacement_top import lru_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lru_in_if.sink           i_req,
    lru_out_if.source        o_rsp
);

    logic [CFG_W-1:0]     r_active;
    logic                 r_in_valid;
    logic [PAGE_BITS-1:0] r_page;
    t_tag_arr             r_tags;
    t_frame_mask          r_valid;
    t_rank_arr            r_rank;
    logic [CNT_W-1:0]     r_filled;
    logic [FAULT_W-1:0]   r_fault;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [FAULT_W-1:0]   r_out_fault;

    logic [FAULT_W-1:0]   n_fault;
    t_rank_arr            n_rank;
    logic [CNT_W-1:0]     active_n;
    logic                 out_free;
    logic                 process;
    t_lookup              lk;

    always_comb begin
        if (r_active == '0) begin
            active_n = CNT_W'(1);
        end else if (int'(r_active) > FRAMES) begin
            active_n = CNT_W'(FRAMES);
        end else begin
            active_n = CNT_W'(r_active);
        end
    end

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || out_free;
    assign process     = r_in_valid && out_free;

    lru_lookup u_lookup (
        .i_page   (r_page),
        .i_tags   (r_tags),
        .i_valid  (r_valid),
        .i_rank   (r_rank),
        .i_active (active_n),
        .i_filled (r_filled),
        .o_lookup (lk)
    );

    assign n_fault = (lk.hit || r_fault == FAULT_MAX) ? r_fault : r_fault + FAULT_W'(1);

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            if (lk.sel[i]) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (lk.fill || r_rank[i] < lk.old_rank)) begin
                n_rank[i] = r_rank[i] + SLOT_W'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= ACTIVE_RESET;
            r_in_valid  <= 1'b0;
            r_valid     <= '0;
            r_rank      <= '0;
            r_filled    <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (process) begin
                r_rank      <= n_rank;
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
                if (lk.fill) begin
                    r_valid  <= r_valid | lk.sel;
                    r_filled <= r_filled + CNT_W'(1);
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_page <= i_req.page_number;
        end
        if (process) begin
            r_out_hit   <= lk.hit;
            r_out_slot  <= lk.slot;
            r_out_fault <= n_fault;
            for (int i = 0; i < FRAMES; i++) begin
                if (!lk.hit && lk.sel[i]) begin
                    r_tags[i] <= r_page;
                end
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.frame_slot  = r_out_slot;
    assign o_rsp.fault_count = r_out_fault;

    a_hit_keeps_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && lk.hit) |=> (r_fault == $past(r_fault)))
        else $error("fault total moved on a hit");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_valid) == int'(r_filled)) && (r_filled <= CNT_W'(FRAMES)))
        else $error("valid frames disagree with fill count");

    a_one_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |-> $onehot(lk.sel))
        else $error("frame select not one-hot");

    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_fault != '0))
        else $error("fault reported with zero total");

endmodule
